FILE: rtl/char_lcd_nibble_interface_core_defines.svh
// Assertion macros used by the character LCD interface RTL.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDNIB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCDNIB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lcdnib_pkg.sv
package lcdnib_pkg;

  localparam int unsigned CountWidth = 12;

  // Request kinds carried in tuser.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_INIT = 2'd1;
  localparam logic [1:0] REQ_CMD  = 2'd2;
  localparam logic [1:0] REQ_CHAR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOW_TICKS    = 2'd0;
  localparam logic [1:0] CFG_SETTLE_TICKS = 2'd1;
  localparam logic [1:0] CFG_LONG_WAIT    = 2'd2;

  localparam logic [7:0]            LOW_TICKS_RESET    = 8'd5;
  localparam logic [7:0]            SETTLE_TICKS_RESET = 8'd40;
  localparam logic [CountWidth-1:0] LONG_WAIT_RESET    = 12'd2000;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;

  localparam logic [3:0] INIT_NIBBLE_WAKE = 4'h3;
  localparam logic [3:0] INIT_NIBBLE_4BIT = 4'h2;
  localparam logic [2:0] INIT_WAKE_PULSES = 3'd3;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_INIT_LOW  = 6'b000010,
    PH_INIT_HIGH = 6'b000100,
    PH_BYTE_LOW  = 6'b001000,
    PH_BYTE_HIGH = 6'b010000,
    PH_LONG      = 6'b100000
  } phase_t;

endpackage

FILE: rtl/char_lcd_nibble_interface_core.sv
// Channel  | Dir | Handshake          | Payload
// s        | in  | s_tvalid/s_tready  | tdata: data_byte; tuser: req_type
// m        | out | m_tvalid/m_tready  | tdata: rs, enable, nibble, busy, accepted
// cfg      | in  | cfg_we             | cfg_index selects register, cfg_data value
//
// Every item is handled at its accepting edge: the controller state is updated there
// and the result lands in the output register, so one item per cycle unless m stalls.
// The output register frees itself when taken, so s_tready stays high while m_tready is.
// A stall on m holds the result and drops s_tready until the result is taken.
// rst is synchronous and active high; it restores the register defaults and idle pins.
module char_lcd_nibble_interface_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] rs_level, [1] enable_level, [5:2] bus_nibble,
                                 // [6] busy_res, [7] accepted
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  `include "char_lcd_nibble_interface_core_defines.svh"

  logic [7:0]                          low_ticks;
  logic [7:0]                          settle_ticks;
  logic [lcdnib_pkg::CountWidth-1:0]   long_wait_ticks;

  lcdnib_pkg::phase_t                  phase, phase_next;
  logic [2:0]                          pulse_index, pulse_index_next;
  logic [lcdnib_pkg::CountWidth-1:0]   wait_count, wait_count_next;
  logic [7:0]                          held_byte, held_byte_next;
  logic                                rs_reg, rs_reg_next;
  logic                                enable_reg, enable_reg_next;
  logic [3:0]                          nibble_reg, nibble_reg_next;
  logic                                acc_next;

  logic                                out_valid;
  logic [7:0]                          out_data;
  logic                                s_accept;

  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_ticks       <= lcdnib_pkg::LOW_TICKS_RESET;
      settle_ticks    <= lcdnib_pkg::SETTLE_TICKS_RESET;
      long_wait_ticks <= lcdnib_pkg::LONG_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdnib_pkg::CFG_LOW_TICKS:    low_ticks       <= cfg_data[7:0];
        lcdnib_pkg::CFG_SETTLE_TICKS: settle_ticks    <= cfg_data[7:0];
        lcdnib_pkg::CFG_LONG_WAIT:    long_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next       = phase;
    pulse_index_next = pulse_index;
    wait_count_next  = wait_count;
    held_byte_next   = held_byte;
    rs_reg_next      = rs_reg;
    enable_reg_next  = enable_reg;
    nibble_reg_next  = nibble_reg;
    acc_next         = 1'b0;

    if (s_tuser == lcdnib_pkg::REQ_TICK) begin
      if (phase != lcdnib_pkg::PH_IDLE) begin
        // A count of zero or one ends the current step on this tick.
        if (wait_count > 12'd1) begin
          wait_count_next = wait_count - 12'd1;
        end else begin
          case (phase)
            lcdnib_pkg::PH_INIT_LOW: begin
              enable_reg_next = 1'b1;
              wait_count_next = {4'd0, settle_ticks};
              phase_next      = lcdnib_pkg::PH_INIT_HIGH;
            end
            lcdnib_pkg::PH_BYTE_LOW: begin
              enable_reg_next = 1'b1;
              wait_count_next = {4'd0, settle_ticks};
              phase_next      = lcdnib_pkg::PH_BYTE_HIGH;
            end
            lcdnib_pkg::PH_INIT_HIGH: begin
              pulse_index_next = pulse_index + 3'd1;
              if (pulse_index_next <= lcdnib_pkg::INIT_WAKE_PULSES) begin
                nibble_reg_next = (pulse_index_next < lcdnib_pkg::INIT_WAKE_PULSES)
                                  ? lcdnib_pkg::INIT_NIBBLE_WAKE
                                  : lcdnib_pkg::INIT_NIBBLE_4BIT;
                enable_reg_next = 1'b0;
                wait_count_next = {4'd0, low_ticks};
                phase_next      = lcdnib_pkg::PH_INIT_LOW;
              end else begin
                phase_next      = lcdnib_pkg::PH_IDLE;
                wait_count_next = '0;
              end
            end
            lcdnib_pkg::PH_BYTE_HIGH: begin
              pulse_index_next = pulse_index + 3'd1;
              if (pulse_index_next == 3'd1) begin
                nibble_reg_next = held_byte[3:0];
                enable_reg_next = 1'b0;
                wait_count_next = {4'd0, low_ticks};
                phase_next      = lcdnib_pkg::PH_BYTE_LOW;
              end else if (!rs_reg && (held_byte == lcdnib_pkg::CMD_CLEAR ||
                                       held_byte == lcdnib_pkg::CMD_HOME)) begin
                phase_next      = lcdnib_pkg::PH_LONG;
                wait_count_next = long_wait_ticks;
              end else begin
                phase_next      = lcdnib_pkg::PH_IDLE;
                wait_count_next = '0;
              end
            end
            default: begin
              phase_next      = lcdnib_pkg::PH_IDLE;
              wait_count_next = '0;
            end
          endcase
        end
      end
    end else if (phase == lcdnib_pkg::PH_IDLE) begin
      acc_next         = 1'b1;
      pulse_index_next = '0;
      enable_reg_next  = 1'b0;
      wait_count_next  = {4'd0, low_ticks};
      phase_next       = (s_tuser == lcdnib_pkg::REQ_INIT) ? lcdnib_pkg::PH_INIT_LOW
                                                           : lcdnib_pkg::PH_BYTE_LOW;
      if (s_tuser == lcdnib_pkg::REQ_INIT) begin
        rs_reg_next     = 1'b0;
        nibble_reg_next = lcdnib_pkg::INIT_NIBBLE_WAKE;
      end else begin
        held_byte_next  = s_tdata;
        rs_reg_next     = (s_tuser == lcdnib_pkg::REQ_CHAR);
        nibble_reg_next = s_tdata[7:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= lcdnib_pkg::PH_IDLE;
      pulse_index <= '0;
      wait_count  <= '0;
      held_byte   <= '0;
      rs_reg      <= 1'b0;
      enable_reg  <= 1'b1;
      nibble_reg  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (s_accept) begin
        phase       <= phase_next;
        pulse_index <= pulse_index_next;
        wait_count  <= wait_count_next;
        held_byte   <= held_byte_next;
        rs_reg      <= rs_reg_next;
        enable_reg  <= enable_reg_next;
        nibble_reg  <= nibble_reg_next;
        out_valid   <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_data <= {acc_next, (phase_next != lcdnib_pkg::PH_IDLE), nibble_reg_next,
                   enable_reg_next, rs_reg_next};
    end
  end

  `LCDNIB_ASSERT_NOW(a_acc_busy, clk, rst, m_tvalid && m_tdata[7], m_tdata[6],
    "accepted result without busy")
  `LCDNIB_ASSERT_NOW(a_idle_count, clk, rst, phase == lcdnib_pkg::PH_IDLE,
    wait_count == '0, "idle with a pending count")
  `LCDNIB_ASSERT_NOW(a_enable_low, clk, rst, !enable_reg,
    phase == lcdnib_pkg::PH_INIT_LOW || phase == lcdnib_pkg::PH_BYTE_LOW,
    "enable low outside a low phase")
  `LCDNIB_ASSERT_NEXT(a_busy_refuse, clk, rst,
    s_accept && s_tuser != lcdnib_pkg::REQ_TICK && phase != lcdnib_pkg::PH_IDLE,
    $stable(phase) && $stable(wait_count), "refused request changed state")

endmodule

FILE: tb/lcd_pin_checker.sv
`timescale 1ns / 100ps

module lcd_pin_checker
  import lcdnib_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output logic        lcd_busy
);

  // Packed in the same order as m_tdata, rs_level in bit 0.
  typedef struct packed {
    logic       accepted;
    logic       busy;
    logic [3:0] nibble;
    logic       enable;
    logic       rs;
  } pins_t;

  pins_t expected_pins[$];

  logic [7:0]            low_ticks_q;
  logic [7:0]            settle_ticks_q;
  logic [CountWidth-1:0] long_wait_q;

  phase_t                ph;
  logic [2:0]            pulse_n;
  logic [CountWidth-1:0] wait_n;
  logic [7:0]            held;
  logic                  rs_q;
  logic                  en_q;
  logic [3:0]            nib_q;

  task automatic reset_model();
    low_ticks_q    = LOW_TICKS_RESET;
    settle_ticks_q = SETTLE_TICKS_RESET;
    long_wait_q    = LONG_WAIT_RESET;
    ph      = PH_IDLE;
    pulse_n = '0;
    wait_n  = '0;
    held    = '0;
    rs_q    = 1'b0;
    en_q    = 1'b1;
    nib_q   = '0;
  endtask

  task automatic go_idle();
    ph     = PH_IDLE;
    wait_n = '0;
  endtask

  task automatic start_pulse(input logic [3:0] nib, input phase_t low_phase);
    nib_q  = nib;
    en_q   = 1'b0;
    wait_n = {4'd0, low_ticks_q};
    ph     = low_phase;
  endtask

  // A count of zero or one both expire on the next tick.
  task automatic count_tick();
    if (wait_n > 1) begin
      wait_n = wait_n - 1'b1;
    end else begin
      case (ph)
        PH_INIT_LOW: begin
          en_q   = 1'b1;
          wait_n = {4'd0, settle_ticks_q};
          ph     = PH_INIT_HIGH;
        end
        PH_BYTE_LOW: begin
          en_q   = 1'b1;
          wait_n = {4'd0, settle_ticks_q};
          ph     = PH_BYTE_HIGH;
        end
        PH_INIT_HIGH: begin
          pulse_n = pulse_n + 1'b1;
          if (pulse_n < INIT_WAKE_PULSES) begin
            start_pulse(INIT_NIBBLE_WAKE, PH_INIT_LOW);
          end else if (pulse_n == INIT_WAKE_PULSES) begin
            start_pulse(INIT_NIBBLE_4BIT, PH_INIT_LOW);
          end else begin
            go_idle();
          end
        end
        PH_BYTE_HIGH: begin
          pulse_n = pulse_n + 1'b1;
          if (pulse_n == 3'd1) begin
            start_pulse(held[3:0], PH_BYTE_LOW);
          end else if (!rs_q && (held == CMD_CLEAR || held == CMD_HOME)) begin
            ph     = PH_LONG;
            wait_n = long_wait_q;
          end else begin
            go_idle();
          end
        end
        default: go_idle();
      endcase
    end
  endtask

  task automatic lcd_step(input logic [1:0] req, input logic [7:0] data_byte,
                          output pins_t pins);
    logic taken;
    taken = 1'b0;
    if (req == REQ_TICK) begin
      if (ph != PH_IDLE) count_tick();
    end else if (ph == PH_IDLE) begin
      taken   = 1'b1;
      pulse_n = '0;
      if (req == REQ_INIT) begin
        rs_q = 1'b0;
        start_pulse(INIT_NIBBLE_WAKE, PH_INIT_LOW);
      end else begin
        held = data_byte;
        rs_q = (req == REQ_CHAR);
        start_pulse(data_byte[7:4], PH_BYTE_LOW);
      end
    end
    pins.rs       = rs_q;
    pins.enable   = en_q;
    pins.nibble   = nib_q;
    pins.busy     = (ph != PH_IDLE);
    pins.accepted = taken;
  endtask

  always @(posedge clk) begin
    pins_t want;
    pins_t got;
    if (rst) begin
      reset_model();
      expected_pins.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW_TICKS:    low_ticks_q    = cfg_data[7:0];
          CFG_SETTLE_TICKS: settle_ticks_q = cfg_data[7:0];
          CFG_LONG_WAIT:    long_wait_q    = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_pins.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("%0t: result %h arrived with no item outstanding", $realtime, m_tdata);
        end else begin
          want = expected_pins.pop_front();
          if (got.rs !== want.rs || got.enable !== want.enable ||
              got.nibble !== want.nibble || got.busy !== want.busy ||
              got.accepted !== want.accepted) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("%0t: pins expected rs=%b en=%b nib=%h busy=%b acc=%b,",
                       $realtime, want.rs, want.enable, want.nibble, want.busy,
                       want.accepted,
                       " got rs=%b en=%b nib=%h busy=%b acc=%b",
                       got.rs, got.enable, got.nibble, got.busy, got.accepted);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        lcd_step(s_tuser, s_tdata, want);
        expected_pins.push_back(want);
      end
    end
    pending  = expected_pins.size();
    lcd_busy = (ph != PH_IDLE);
  end

endmodule

FILE: tb/char_lcd_nibble_interface_core_tb.sv
`timescale 1ns / 100ps

module char_lcd_nibble_interface_core_tb;
  import lcdnib_pkg::*;

  // Not a register; writes to it must leave the timing alone.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int unsigned RandomTarget = 450;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  int   fail_count;
  int   pending;
  logic lcd_busy;

  bit   no_idle;
  int   counted;
  int   taken_reqs;
  int   refused_reqs;
  int   timing_sets;

  char_lcd_nibble_interface_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lcd_pin_checker pin_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .lcd_busy(lcd_busy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("char_lcd_nibble_interface_core_tb: errors");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Result side: stall a random number of cycles before each item.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Leaves tvalid high on return so a back-to-back item keeps it asserted.
  task automatic send(input logic [1:0] req, input logic [7:0] data_byte);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (req == REQ_TICK) begin
      if (lcd_busy) counted++;
    end else if (lcd_busy) begin
      refused_reqs++;
    end else begin
      taken_reqs++;
      counted++;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= data_byte;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Tick until the controller is idle again, now and then slipping in a
  // request that must be refused.
  task automatic run_out(input int noise_odds);
    while (lcd_busy) begin
      if ($urandom_range(1, noise_odds) == 1)
        send(2'($urandom_range(1, 3)), 8'($urandom));
      else
        send(REQ_TICK, 8'($urandom));
    end
  endtask

  // The sender holds off until every result is back before touching timing.
  task automatic set_timing(input logic [7:0] low, input logic [7:0] settle,
                            input logic [11:0] long_wait);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_TICKS;
    cfg_data  <= {4'd0, low};
    @(negedge clk);
    cfg_index <= CFG_SETTLE_TICKS;
    cfg_data  <= {4'd0, settle};
    @(negedge clk);
    cfg_index <= CFG_LONG_WAIT;
    cfg_data  <= long_wait;
    @(negedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 12'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    timing_sets++;
  endtask

  initial begin
    int n;
    logic [1:0] req;
    logic [7:0] data_byte;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_TICK;
    cfg_we    = 1'b0;
    cfg_index = CFG_LOW_TICKS;
    cfg_data  = '0;
    no_idle   = 1'b0;
    counted      = 0;
    taken_reqs   = 0;
    refused_reqs = 0;
    timing_sets  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset timing first.
    send(REQ_TICK, 8'hFF);
    send(REQ_INIT, 8'hA5);
    send(REQ_CHAR, 8'h55);
    send(REQ_INIT, 8'h00);
    send(REQ_CMD, 8'h01);
    run_out(12);
    send(REQ_CHAR, CMD_CLEAR);
    run_out(16);
    send(REQ_TICK, 8'h00);

    // Zero counts behave as one.
    set_timing(8'd0, 8'd0, 12'd0);
    send(REQ_CMD, CMD_CLEAR);
    run_out(4);
    send(REQ_INIT, 8'h3C);
    run_out(4);
    send(REQ_CHAR, CMD_HOME);
    run_out(4);

    set_timing(8'd9, 8'd6, 12'd60);
    send(REQ_CMD, CMD_HOME);
    run_out(16);
    send(REQ_CMD, 8'h00);
    run_out(16);
    send(REQ_CHAR, 8'h80);
    run_out(16);

    set_timing(8'd1, 8'd1, 12'd1);
    send(REQ_CMD, CMD_CLEAR);
    run_out(4);
    send(REQ_CMD, 8'hFF);
    run_out(4);

    // Random part: mostly well-formed sequences with random content.
    n = counted;
    while (counted - n < RandomTarget) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0)
        set_timing(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                   12'($urandom_range(0, 15)));
      if ($urandom_range(0, 9) == 0) begin
        send(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        req = 2'($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0)
          data_byte = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
        else
          data_byte = 8'($urandom);
        send(req, data_byte);
      end
      run_out($urandom_range(3, 16));
    end
    no_idle = 1'b0;

    s_tvalid <= 1'b0;
    n = 0;
    while (pending != 0 && n < 2000) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);

    $display("Sent %0d timed items: %0d requests taken, %0d refused while busy.",
             counted, taken_reqs, refused_reqs);
    $display("Timing was reprogrammed %0d times, zero counts and long waits included.",
             timing_sets);
    if (fail_count == 0 && pending == 0) begin
      $display("char_lcd_nibble_interface_core_tb: clean");
    end else begin
      if (pending != 0) $display("%0d results never arrived", pending);
      $display("char_lcd_nibble_interface_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lcdnib_pkg.sv
rtl/char_lcd_nibble_interface_core.sv
tb/lcd_pin_checker.sv
tb/char_lcd_nibble_interface_core_tb.sv
